>>> hdl/ragcd_pkg.sv
// Shared definitions for the rational arithmetic unit with gcd reduction.
// Operation and compare codes, and the status bundle of the divider.
// No dependencies.
package ragcd_pkg;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_CMP = 3'd4;

   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_LT = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;

   localparam int RES_NUM_W = 33;
   localparam int RES_DEN_W = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> hdl/rational_arith_gcd_reduce.sv
// Rational add/sub/mul/div/compare with reduction by the gcd of the result.
// One shared multiplier, the binary gcd loop and the bit-serial divider do the work;
// one beat is in work at a time. An error goes straight to the final step, a compare
// or a zero result skips the gcd, and the two divides run only when the gcd is not 1.
// Reset (synchronous, active high) returns the sequencer to idle, drops rsp_valid.
module rational_arith_gcd_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [2:0]                               req_mode,
   input  logic signed [OPERAND_WIDTH-1:0]          req_a_num,
   input  logic [OPERAND_WIDTH-1:0]                 req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]          req_b_num,
   input  logic [OPERAND_WIDTH-1:0]                 req_b_den,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ragcd_pkg::RES_NUM_W-1:0]   rsp_res_num,
   output logic [ragcd_pkg::RES_DEN_W-1:0]          rsp_res_den,
   output logic [1:0]                               rsp_cmp_result,
   output logic                                     rsp_error_flag
);
   import ragcd_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * OPERAND_WIDTH + 1;              // product plus carry
   localparam int XW = (PW > RES_NUM_W) ? PW : RES_NUM_W;  // numerator output span
   localparam int DW = (PW > RES_DEN_W) ? PW : RES_DEN_W;  // denominator output span

   // Sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL1 = 4'd1;
   localparam logic [3:0] ST_MUL2 = 4'd2;
   localparam logic [3:0] ST_MUL3 = 4'd3;
   localparam logic [3:0] ST_SUM  = 4'd4;
   localparam logic [3:0] ST_RED  = 4'd5;
   localparam logic [3:0] ST_GCD  = 4'd6;
   localparam logic [3:0] ST_DIVN = 4'd7;
   localparam logic [3:0] ST_DIVD = 4'd8;
   localparam logic [3:0] ST_FIN  = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    mode_ff, mode_in;
   logic          na_ff, na_in, nb_ff, nb_in;
   logic [W-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [W-1:0]  ad_ff, ad_in, bd_ff, bd_in;
   logic [PW-1:0] x_ff, x_in;      // numerator magnitude
   logic [PW-1:0] y_ff, y_in;      // denominator
   logic [2*W-1:0] d_ff, d_in;     // product of denominators for add/sub
   logic [PW-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic          sgn_ff, sgn_in;
   logic [1:0]    cmp_ff, cmp_in;
   logic          err_ff, err_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RES_NUM_W-1:0] res_num_ff, res_num_in;
   logic [RES_DEN_W-1:0] res_den_ff, res_den_in;
   logic [1:0]           res_cmp_ff, res_cmp_in;
   logic                 res_err_ff, res_err_in;

   // Shared multiplier
   logic [W-1:0]   mul_a, mul_b;
   logic [2*W-1:0] mul_p;

   // Divider hookup
   logic          div_start;
   logic [PW-1:0] div_dividend;
   logic [PW-1:0] div_quo;
   div_stat_type  div_stat;

   // Operand split at the request port
   logic [W-1:0]  a_raw, b_raw, a_mag, b_mag;
   logic          req_bad;

   // Datapath helpers
   logic          ny;
   logic [PW-1:0] gdiff_ab, gdiff_ba;
   logic [XW-1:0] x_ext, x_neg;
   logic [DW-1:0] y_ext;
   logic          req_fire, rsp_free;

   assign a_raw = req_a_num;
   assign b_raw = req_b_num;
   assign a_mag = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
   assign b_mag = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign req_bad = (req_mode > MODE_CMP) || (req_a_den == '0) || (req_b_den == '0)
                    || ((req_mode == MODE_DIV) && (b_mag == '0));

   // Pick multiplier operands by step and operation.
   always_comb begin
      mul_a = ma_ff;
      mul_b = bd_ff;
      case (state_ff)
         ST_MUL1: begin
            mul_a = ma_ff;
            mul_b = (mode_ff == MODE_MUL) ? mb_ff : bd_ff;
         end
         ST_MUL2: begin
            mul_a = ad_ff;
            mul_b = (mode_ff == MODE_MUL) ? bd_ff : mb_ff;
         end
         ST_MUL3: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         default: begin
            mul_a = ma_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign ny       = (mode_ff == MODE_SUB) ? !nb_ff : nb_ff;
   assign gdiff_ab = ga_ff - gb_ff;
   assign gdiff_ba = gb_ff - ga_ff;
   assign x_ext    = XW'(x_ff);
   assign x_neg    = ~x_ext + 1'b1;
   assign y_ext    = DW'(y_ff);

   // Divide the numerator first, then the denominator, by the odd gcd part.
   assign div_dividend = (state_ff == ST_GCD) ? x_ff : y_ff;
   assign div_start    = ((state_ff == ST_GCD) && (ga_ff == gb_ff) && (ga_ff != PW'(1)))
                         || ((state_ff == ST_DIVN) && div_stat.done);

   ragcd_divider #(
      .WIDTH (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (ga_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      ad_in        = ad_ff;
      bd_in        = bd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      d_in         = d_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      sgn_in       = sgn_ff;
      cmp_in       = cmp_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_cmp_in   = res_cmp_ff;
      res_err_in   = res_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Capture operands as sign and magnitude; clear the result.
               mode_in  = req_mode;
               na_in    = a_raw[W-1];
               nb_in    = b_raw[W-1];
               ma_in    = a_mag;
               mb_in    = b_mag;
               ad_in    = req_a_den;
               bd_in    = req_b_den;
               x_in     = '0;
               y_in     = '0;
               sgn_in   = 1'b0;
               cmp_in   = CMP_EQ;
               err_in   = req_bad;
               state_in = req_bad ? ST_FIN : ST_MUL1;
            end
         end
         ST_MUL1: begin
            x_in     = PW'(mul_p);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            y_in = PW'(mul_p);
            if (mode_ff inside {MODE_MUL, MODE_DIV}) begin
               sgn_in   = na_ff ^ nb_ff;
               state_in = ST_RED;
            end else if (mode_ff == MODE_CMP) begin
               state_in = ST_SUM;
            end else begin
               state_in = ST_MUL3;
            end
         end
         ST_MUL3: begin
            d_in     = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (mode_ff == MODE_CMP) begin
               // Order a_num*b_den against b_num*a_den.
               if (na_ff != nb_ff)
                  cmp_in = na_ff ? CMP_LT : CMP_GT;
               else if (x_ff == y_ff)
                  cmp_in = CMP_EQ;
               else if (!na_ff)
                  cmp_in = (x_ff < y_ff) ? CMP_LT : CMP_GT;
               else
                  cmp_in = (x_ff > y_ff) ? CMP_LT : CMP_GT;
               x_in     = '0;
               y_in     = '0;
               state_in = ST_FIN;
            end else begin
               // Signed-magnitude sum of the cross products.
               if (na_ff == ny) begin
                  x_in   = x_ff + y_ff;
                  sgn_in = na_ff;
               end else if (x_ff >= y_ff) begin
                  x_in   = x_ff - y_ff;
                  sgn_in = na_ff;
               end else begin
                  x_in   = y_ff - x_ff;
                  sgn_in = ny;
               end
               y_in     = PW'(d_ff);
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            if (x_ff == '0) begin
               // Zero numerator reduces to 0/1.
               y_in     = PW'(1);
               sgn_in   = 1'b0;
               state_in = ST_FIN;
            end else begin
               ga_in    = x_ff;
               gb_in    = y_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (ga_ff == gb_ff) begin
               state_in = (ga_ff == PW'(1)) ? ST_FIN : ST_DIVN;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               // Common factor two: drop it from the result right away.
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               x_in  = x_ff >> 1;
               y_in  = y_ff >> 1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = gdiff_ab >> 1;
            end else begin
               gb_in = gdiff_ba >> 1;
            end
         end
         ST_DIVN: begin
            if (div_stat.done) begin
               x_in     = div_quo;
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_stat.done) begin
               y_in     = div_quo;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold until the output register is free, then load it.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               res_num_in   = sgn_ff ? x_neg[RES_NUM_W-1:0] : x_ext[RES_NUM_W-1:0];
               res_den_in   = y_ext[RES_DEN_W-1:0];
               res_cmp_in   = cmp_ff;
               res_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      ad_ff      <= ad_in;
      bd_ff      <= bd_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      d_ff       <= d_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      sgn_ff     <= sgn_in;
      cmp_ff     <= cmp_in;
      err_ff     <= err_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_cmp_ff <= res_cmp_in;
      res_err_ff <= res_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_num    = res_num_ff;
   assign rsp_res_den    = res_den_ff;
   assign rsp_cmp_result = res_cmp_ff;
   assign rsp_error_flag = res_err_ff;

   a_error_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_err_ff |->
         res_num_ff == '0 && res_den_ff == '0 && res_cmp_ff == CMP_EQ)
      else $error("error beat carries a nonzero result");

   a_gcd_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> ga_ff != '0 && gb_ff != '0)
      else $error("gcd loop entered with a zero operand");

   a_load_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result beat raised outside the final step");

   a_div_in_divide_steps : assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIVN || state_ff == ST_DIVD)
      else $error("divider running outside the divide steps");

endmodule

>>> hdl/ragcd_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on ragcd_pkg (div_stat_type).
module ragcd_divider #(
   parameter int WIDTH = 33
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WIDTH-1:0]          dividend,
   input  logic [WIDTH-1:0]          divisor,
   output logic [WIDTH-1:0]          quotient,
   output ragcd_pkg::div_stat_type   stat
);
   import ragcd_pkg::*;

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   // Divisor is held steady by the caller for the whole run.
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a run");

   a_done_on_last : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == LAST |=> done_ff)
      else $error("divider missed its last step");

endmodule

>>> dv/rational_arith_gcd_reduce_tb.sv
// Self-checking testbench for rational_arith_gcd_reduce: directed and random beats
// checked against an in-bench fraction predictor (cross products, gcd reduction).
// Depends on hdl/ragcd_pkg.sv, hdl/ragcd_divider.sv and hdl/rational_arith_gcd_reduce.sv.
module rational_arith_gcd_reduce_tb;
   import ragcd_pkg::*;

   localparam int OPW         = 16;
   localparam int RANDOM_OPS  = 450;
   // Quiet spell at the end of the run, after all results are back.
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [2:0]     mode;
      logic [OPW-1:0] a_num;
      logic [OPW-1:0] a_den;
      logic [OPW-1:0] b_num;
      logic [OPW-1:0] b_den;
   } rat_op_type;

   typedef struct packed {
      logic [RES_NUM_W-1:0] res_num;
      logic [RES_DEN_W-1:0] res_den;
      logic [1:0]           cmp_result;
      logic                 error_flag;
   } rat_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [2:0]                  req_mode = MODE_ADD;
   logic signed [OPW-1:0]       req_a_num = '0;
   logic [OPW-1:0]              req_a_den = '0;
   logic signed [OPW-1:0]       req_b_num = '0;
   logic [OPW-1:0]              req_b_den = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [RES_NUM_W-1:0] rsp_res_num;
   logic [RES_DEN_W-1:0]        rsp_res_den;
   logic [1:0]                  rsp_cmp_result;
   logic                        rsp_error_flag;

   rat_op_type     pending_ops[$];
   rat_result_type expected_results[$];
   int             mismatch_count = 0;

   // Set at a rising edge when the request beat was taken; read by the driver.
   logic        req_beat_seen = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          stall_cycle = 0;
   int          stall_style = 0;

   always #1 clock = ~clock;

   rational_arith_gcd_reduce #(
      .OPERAND_WIDTH(OPW)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_res_num    (rsp_res_num),
      .rsp_res_den    (rsp_res_den),
      .rsp_cmp_result (rsp_cmp_result),
      .rsp_error_flag (rsp_error_flag)
   );

   // Compute the reduced fraction, or the compare outcome, for one request beat.
   // Work in sign and magnitude so that the gcd runs on plain unsigned values.
   function automatic rat_result_type predict_rational(rat_op_type op);
      logic [OPW-1:0]  mag16_a, mag16_b;
      logic            neg_a, neg_b, neg_r, neg_y;
      longint unsigned mag_a, mag_b, den_a, den_b;
      longint unsigned lhs, rhs, mag_r, den_r, x, y, t;
      rat_result_type  r;
      r      = '0;
      neg_a  = op.a_num[OPW-1];
      neg_b  = op.b_num[OPW-1];
      mag16_a = neg_a ? (~op.a_num + 1'b1) : op.a_num;
      mag16_b = neg_b ? (~op.b_num + 1'b1) : op.b_num;
      mag_a  = 64'(mag16_a);
      mag_b  = 64'(mag16_b);
      den_a  = 64'(op.a_den);
      den_b  = 64'(op.b_den);
      neg_r  = 1'b0;
      mag_r  = 0;
      den_r  = 0;
      if (op.mode > MODE_CMP || op.a_den == '0 || op.b_den == '0) begin
         r.error_flag = 1'b1;
      end else if (op.mode == MODE_CMP) begin
         // Order a and b by a_num*b_den against b_num*a_den.
         lhs = mag_a * den_b;
         rhs = mag_b * den_a;
         neg_a = neg_a && mag_a != 0;
         neg_b = neg_b && mag_b != 0;
         if (neg_a != neg_b)
            r.cmp_result = neg_a ? CMP_LT : CMP_GT;
         else if (lhs == rhs)
            r.cmp_result = CMP_EQ;
         else if (!neg_a)
            r.cmp_result = (lhs < rhs) ? CMP_LT : CMP_GT;
         else
            r.cmp_result = (lhs > rhs) ? CMP_LT : CMP_GT;
      end else if (op.mode == MODE_DIV && mag_b == 0) begin
         r.error_flag = 1'b1;
      end else begin
         if (op.mode == MODE_ADD || op.mode == MODE_SUB) begin
            lhs   = mag_a * den_b;
            rhs   = mag_b * den_a;
            neg_y = (op.mode == MODE_SUB) ? !neg_b : neg_b;
            if (neg_a == neg_y) begin
               neg_r = neg_a;
               mag_r = lhs + rhs;
            end else if (lhs >= rhs) begin
               neg_r = neg_a;
               mag_r = lhs - rhs;
            end else begin
               neg_r = neg_y;
               mag_r = rhs - lhs;
            end
            den_r = den_a * den_b;
         end else if (op.mode == MODE_MUL) begin
            mag_r = mag_a * mag_b;
            neg_r = neg_a != neg_b;
            den_r = den_a * den_b;
         end else begin
            // Divide: the divisor's sign moves up to the result numerator.
            mag_r = mag_a * den_b;
            neg_r = neg_a != neg_b;
            den_r = den_a * mag_b;
         end
         x = mag_r;
         y = den_r;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         if (x != 0) begin
            mag_r = mag_r / x;
            den_r = den_r / x;
         end
         if (mag_r == 0)
            neg_r = 1'b0;
         r.res_num = RES_NUM_W'(neg_r ? (~mag_r + 1) : mag_r);
         r.res_den = RES_DEN_W'(den_r);
      end
      return r;
   endfunction

   task automatic push_op(logic [2:0] mode, logic [OPW-1:0] a_num, logic [OPW-1:0] a_den,
                          logic [OPW-1:0] b_num, logic [OPW-1:0] b_den);
      rat_op_type op;
      op = '{mode: mode, a_num: a_num, a_den: a_den, b_num: b_num, b_den: b_den};
      pending_ops.push_back(op);
   endtask

   // Mix full-range numerators with small ones, so that reductions and equal
   // compares come up often.
   function automatic logic [OPW-1:0] rand_num();
      if ($urandom_range(0, 1) == 0)
         return OPW'($urandom);
      return OPW'($urandom_range(0, 40)) - OPW'(20);
   endfunction

   function automatic logic [OPW-1:0] rand_den();
      if ($urandom_range(0, 2) == 0)
         return OPW'($urandom);
      return OPW'($urandom_range(1, 24));
   endfunction

   // Driver: present the next pending beat at the falling edge. Send in bursts
   // of random length and hold valid low for a random gap between bursts; a
   // gap of zero keeps valid high back to back.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_seen) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            req_valid <= 1'b1;
            req_mode  <= pending_ops[0].mode;
            req_a_num <= pending_ops[0].a_num;
            req_a_den <= pending_ops[0].a_den;
            req_b_num <= pending_ops[0].b_num;
            req_b_den <= pending_ops[0].b_den;
            void'(pending_ops.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: pick a new stall style at random on each wrap of stall_cycle. Styles are
   // always ready, a coin toss per cycle, and ready with a chance of one in four.
   always @(negedge clock) begin
      if (stall_cycle == 149) begin
         stall_cycle <= 0;
         stall_style <= $urandom_range(0, 2);
      end else begin
         stall_cycle <= stall_cycle + 1;
      end
      if (reset)
         rsp_ready <= 1'b0;
      else if (stall_style == 0)
         rsp_ready <= 1'b1;
      else if (stall_style == 1)
         rsp_ready <= $urandom_range(0, 1);
      else
         rsp_ready <= ($urandom_range(0, 3) == 0);
   end

   // Request monitor: on each taken beat, predict its result and queue it.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         req_beat_seen <= 1'b1;
         expected_results.push_back(predict_rational('{mode: req_mode, a_num: req_a_num,
            a_den: req_a_den, b_num: req_b_num, b_den: req_b_den}));
      end else begin
         req_beat_seen <= 1'b0;
      end
   end

   // Result monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rat_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_results.pop_front();
            if (rsp_res_num !== want.res_num) begin
               $error("res_num: expected %0d, got %0d", $signed(want.res_num), rsp_res_num);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_res_den !== want.res_den) begin
               $error("res_den: expected %0d, got %0d", want.res_den, rsp_res_den);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_cmp_result !== want.cmp_result) begin
               $error("cmp_result: expected %0d, got %0d", want.cmp_result, rsp_cmp_result);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_error_flag !== want.error_flag) begin
               $error("error_flag: expected %0d, got %0d", want.error_flag, rsp_error_flag);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   initial begin : stimulus
      logic [2:0]     mode;
      logic [OPW-1:0] a_num, a_den, b_num, b_den;
      int             kind;

      // Directed beats: field extremes, every operation, the error cases.
      push_op(MODE_ADD, 16'sd1, 16'd2, 16'sd1, 16'd3);
      push_op(MODE_SUB, 16'sd1, 16'd2, 16'sd1, 16'd2);           // zero numerator -> 0/1
      push_op(MODE_ADD, 16'h8000, 16'd1, 16'h8000, 16'd1);
      push_op(MODE_SUB, 16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFE);
      push_op(MODE_ADD, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      push_op(MODE_MUL, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      push_op(MODE_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
      push_op(MODE_MUL, 16'sd0, 16'd5, 16'sd7, 16'd3);
      push_op(MODE_DIV, 16'sd3, 16'd4, -16'sd3, 16'd8);          // sign moves from divisor
      push_op(MODE_DIV, 16'h8000, 16'hFFFF, 16'h8000, 16'd1);
      push_op(MODE_DIV, 16'sd5, 16'd7, 16'sd0, 16'd3);           // divide by zero
      push_op(MODE_ADD, 16'sd5, 16'd0, 16'sd1, 16'd3);           // zero denominator
      push_op(MODE_CMP, 16'sd5, 16'd4, 16'sd1, 16'd0);
      push_op(MODE_MUL, 16'sd5, 16'd0, 16'sd1, 16'd0);
      push_op(MODE_DIV, 16'sd2, 16'd0, 16'sd0, 16'd3);
      push_op(MODE_CMP, 16'sd1, 16'd2, 16'sd2, 16'd4);           // equal
      push_op(MODE_CMP, -16'sd1, 16'd3, 16'sd1, 16'd3);          // less, sign differs
      push_op(MODE_CMP, 16'h7FFF, 16'd1, 16'h8000, 16'd1);       // greater
      push_op(MODE_CMP, -16'sd1, 16'd2, -16'sd1, 16'd3);         // less, both negative
      push_op(MODE_CMP, 16'sd0, 16'd5, 16'sd0, 16'hFFFF);
      for (int i = 1; i <= 3; i++)                                // undefined modes
         push_op(MODE_CMP + 3'(i), 16'sd1, 16'd2, 16'sd1, 16'd2);

      // Random beats: mostly well-formed operations, with a sprinkle of
      // zero denominators, divides by zero and undefined modes.
      for (int i = 0; i < RANDOM_OPS; i++) begin
         kind  = $urandom_range(0, 19);
         mode  = (kind == 0) ? MODE_CMP + 3'($urandom_range(1, 3))
                             : 3'($urandom_range(0, MODE_CMP));
         a_num = rand_num();
         b_num = rand_num();
         a_den = rand_den();
         b_den = rand_den();
         if (kind == 1)
            a_den = '0;
         if (kind == 2)
            b_den = '0;
         if (kind == 3)
            b_num = '0;
         push_op(mode, a_num, a_den, b_num, b_den);
      end

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Drain: all beats sent, then all results back, then a quiet spell so
      // that any stray result beat is caught.
      while (pending_ops.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("rational_arith_gcd_reduce_tb: PASS");
      else
         $display("rational_arith_gcd_reduce_tb: FAIL");
      $finish;
   end

   // Watchdog: end the run with a fail, far past the slowest correct run.
   initial begin
      #2000000;
      $display("rational_arith_gcd_reduce_tb: FAIL");
      $finish;
   end

endmodule

>>> rational_arith_gcd_reduce.f
hdl/ragcd_pkg.sv
hdl/ragcd_divider.sv
hdl/rational_arith_gcd_reduce.sv
dv/rational_arith_gcd_reduce_tb.sv
